// ----- sv/assert_macros.svh -----
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: lbl");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("%m: lbl");
`endif

// ----- sv/pakd_pkg.sv -----
`default_nettype none
package pakd_pkg;
  localparam int unsigned KeyBlocksDefault = 4;

  typedef enum logic [2:0] {
    KIND_AK   = 3'd0,
    KIND_KDK  = 3'd1,
    KIND_TEK  = 3'd2,
    KIND_MSK  = 3'd3,
    KIND_EMSK = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    WANT_TEK = 2'd0,
    WANT_MSK = 2'd1,
    WANT_ALL = 2'd2,
    WANT_ALT = 2'd3
  } wanted_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_DERIVE,
    ST_OUT
  } state_e;

  // control from sequencer to the round unit
  typedef struct packed {
    logic         start;
    logic [127:0] block;
  } aes_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] block;
  } aes_rsp_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon_next(input logic [7:0] x);
    return xtime(x);
  endfunction
endpackage
`default_nettype wire

// ----- sv/pakd_aes_core.sv -----
`default_nettype none
module pakd_aes_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [127:0]      key_i,
  input  wire pakd_pkg::aes_req_t req_i,
  output pakd_pkg::aes_rsp_t     rsp_o
);
  import pakd_pkg::*;

  // one round per cycle, round key generated on the fly
  logic         busy_q, busy_d;
  logic [3:0]   rnd_q, rnd_d;
  logic [127:0] st_q, st_d, rk_q, rk_d;
  logic [7:0]   rc_q, rc_d;
  logic         done_q, done_d;

  logic [127:0] rk_nx, sub, shf, mix;
  logic [31:0]  w3, tw;

  always_comb begin
    w3 = rk_q[31:0];
    tw = {sbox(w3[23:16]) ^ rc_q, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    rk_nx[127:96] = rk_q[127:96] ^ tw;
    rk_nx[95:64]  = rk_q[95:64] ^ rk_nx[127:96];
    rk_nx[63:32]  = rk_q[63:32] ^ rk_nx[95:64];
    rk_nx[31:0]   = rk_q[31:0] ^ rk_nx[63:32];
  end

  // byte i of the block sits at bits [127-8i -: 8]
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sub[127-8*i -: 8] = sbox(st_q[127-8*i -: 8]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shf[127-8*(r+4*c) -: 8] = sub[127-8*(r+4*((c+r)%4)) -: 8];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, al;
      a0 = shf[127-32*c -: 8];
      a1 = shf[119-32*c -: 8];
      a2 = shf[111-32*c -: 8];
      a3 = shf[103-32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      mix[127-32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      mix[119-32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      mix[111-32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      mix[103-32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
  end

  always_comb begin
    busy_d = busy_q;
    rnd_d  = rnd_q;
    st_d   = st_q;
    rk_d   = rk_q;
    rc_d   = rc_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      rnd_d  = 4'd1;
      st_d   = req_i.block ^ key_i;
      rk_d   = key_i;
      rc_d   = 8'h01;
    end else if (busy_q) begin
      st_d  = ((rnd_q == 4'd10) ? shf : mix) ^ rk_nx;
      rk_d  = rk_nx;
      rc_d  = rcon_next(rc_q);
      rnd_d = rnd_q + 4'd1;
      if (rnd_q == 4'd10) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      rnd_q  <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    rk_q <= rk_d;
    rc_q <= rc_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.block = st_q;

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_done_after_last_round, clk_i, rst_ni, (busy_q && rnd_q == 4'd10 && !req_i.start) |=> done_q)
  `ASSERT_NEVER(a_no_start_busy, clk_i, rst_ni, req_i.start && busy_q)
  `ASSERT_IMPL(a_rnd_range, clk_i, rst_ni, busy_q |-> (rnd_q >= 4'd1 && rnd_q <= 4'd10))
endmodule
`default_nettype wire

// ----- sv/psk_aes_key_derivation_top.sv -----
`default_nettype none
// EAP-PSK key derivation on one AES-128 engine that does one round per cycle. The start
// edge loads block xor key and the rounds follow. The base block runs first; each later
// derived block starts only once the previous beat has been taken, so a beat waiting on
// out_stall_i holds back the rest. Mode 0 returns AK then KDK. Mode 1 runs one
// encryption for the base block and then one per result: TEK, KEY_BLOCKS MSK blocks
// and KEY_BLOCKS EMSK blocks as wanted selects. Each result is held in an output
// register until taken; in_stall_o stays high from acceptance of a request until its
// last beat has been taken.
module psk_aes_key_derivation_top #(
  parameter int unsigned KEY_BLOCKS = pakd_pkg::KeyBlocksDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        func_i,
  input  wire logic [63:0] key_hi_i,
  input  wire logic [63:0] key_lo_i,
  input  wire logic [63:0] rand_hi_i,
  input  wire logic [63:0] rand_lo_i,
  input  wire logic [1:0]  wanted_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       kind_o,
  output logic [1:0]       part_o,
  output logic [63:0]      value_hi_o,
  output logic [63:0]      value_lo_o,
  output logic             last_o
);
  import pakd_pkg::*;

  // counter reaches 2*KEY_BLOCKS+1
  localparam int unsigned CntW = $clog2(2 * KEY_BLOCKS + 2);
  localparam logic [CntW-1:0] CntMsk0  = CntW'(2);
  localparam logic [CntW-1:0] CntEmsk0 = CntW'(KEY_BLOCKS + 2);
  localparam logic [CntW-1:0] CntMskL  = CntW'(KEY_BLOCKS + 1);
  localparam logic [CntW-1:0] CntEmskL = CntW'(2 * KEY_BLOCKS + 1);

  state_e st_q, st_d;
  logic [127:0] key_q, base_q, base_d;
  logic         func_q;
  wanted_e      want_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic         ov_q, ov_d;
  logic [2:0]   kind_q, kind_d;
  logic [1:0]   part_q, part_d;
  logic [127:0] val_q, val_d;
  logic         last_q, last_d;
  logic         in_acc, out_acc;
  aes_req_t     req;
  aes_rsp_t     rsp;
  logic         fin;
  logic [127:0] aes_key;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // the first encryption starts on the accepting edge, before key_q holds the new key
  assign aes_key = (st_q == ST_IDLE) ? {key_hi_i, key_lo_i} : key_q;

  pakd_aes_core u_aes (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .key_i (aes_key),
    .req_i (req),
    .rsp_o (rsp)
  );

  // last block for this request
  always_comb begin
    if (!func_q) begin
      fin = (cnt_q == CntW'(2));
    end else begin
      unique case (want_q)
        WANT_TEK: fin = (cnt_q == CntW'(1));
        WANT_MSK: fin = (cnt_q == CntMskL);
        default:  fin = (cnt_q == CntEmskL);
      endcase
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:   if (in_acc) st_d = ST_BASE;
      ST_BASE:   if (rsp.done) st_d = ST_DERIVE;
      ST_DERIVE: if (rsp.done) st_d = ST_OUT;
      ST_OUT:    if (out_acc) st_d = last_q ? ST_IDLE : ST_DERIVE;
      default:   st_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    req.start = 1'b0;
    req.block = base_q ^ {120'd0, 8'(cnt_q)};
    base_d = base_q;
    cnt_d  = cnt_q;
    ov_d   = ov_q;
    kind_d = kind_q;
    part_d = part_q;
    val_d  = val_q;
    last_d = last_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          req.start = 1'b1;
          req.block = func_i ? {rand_hi_i, rand_lo_i} : 128'd0;
          cnt_d = CntW'(1);
        end
      end
      ST_BASE: begin
        if (rsp.done) begin
          base_d = rsp.block;
          req.start = 1'b1;
          req.block = rsp.block ^ {120'd0, 8'(cnt_q)};
        end
      end
      ST_DERIVE: begin
        if (rsp.done) begin
          val_d  = rsp.block;
          last_d = fin;
          ov_d   = 1'b1;
          if (!func_q) begin
            kind_d = (cnt_q == CntW'(1)) ? KIND_AK : KIND_KDK;
            part_d = 2'd0;
          end else if (cnt_q == CntW'(1)) begin
            kind_d = KIND_TEK;
            part_d = 2'd0;
          end else if (cnt_q < CntEmsk0) begin
            kind_d = KIND_MSK;
            part_d = 2'(cnt_q - CntMsk0);
          end else begin
            kind_d = KIND_EMSK;
            part_d = 2'(cnt_q - CntEmsk0);
          end
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          ov_d = 1'b0;
          if (!last_q) begin
            cnt_d = cnt_q + CntW'(1);
            req.start = 1'b1;
            req.block = base_q ^ {120'd0, 8'(cnt_q + CntW'(1))};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ov_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q  <= {key_hi_i, key_lo_i};
      func_q <= func_i;
      want_q <= wanted_e'(wanted_i);
    end
    base_q <= base_d;
    kind_q <= kind_d;
    part_q <= part_d;
    val_q  <= val_d;
    last_q <= last_d;
  end

  assign in_stall_o  = (st_q != ST_IDLE);
  assign out_valid_o = ov_q;
  assign kind_o      = kind_q;
  assign part_o      = part_q;
  assign value_hi_o  = val_q[127:64];
  assign value_lo_o  = val_q[63:0];
  assign last_o      = last_q;

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_valid_only_in_out, clk_i, rst_ni, ov_q |-> (st_q == ST_OUT))
  `ASSERT_IMPL(a_idle_after_last, clk_i, rst_ni, (out_acc && last_q) |=> (st_q == ST_IDLE))
  `ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > CntEmskL)
endmodule
`default_nettype wire

// ----- bench/pakd_checker.sv -----
`timescale 1ns / 100ps
module pakd_checker #(
  parameter int unsigned KEY_BLOCKS = pakd_pkg::KeyBlocksDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        func_i,
  input  logic [63:0] key_hi_i,
  input  logic [63:0] key_lo_i,
  input  logic [63:0] rand_hi_i,
  input  logic [63:0] rand_lo_i,
  input  logic [1:0]  wanted_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  kind_i,
  input  logic [1:0]  part_i,
  input  logic [63:0] value_hi_i,
  input  logic [63:0] value_lo_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);
  import pakd_pkg::*;

  typedef struct packed {
    kind_e        kind;
    logic [1:0]   part;
    logic [127:0] value;
    logic         last;
  } key_block_t;

  key_block_t key_block_q[$];

  // substitution table built from the field inverse and affine map
  logic [7:0] sub_tab [256];

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  initial begin
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++)
        if (gmul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sub_tab[x] = s;
    end
  end

  function automatic logic [7:0] dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte 0 is the top of the 128-bit word
  function automatic logic [127:0] cipher(input logic [127:0] key, input logic [127:0] pt);
    logic [7:0] rk [176];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] w [4];
    logic [7:0] rc, f, a0, a1, a2, a3, al;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) rk[i] = key[127-8*i -: 8];
    rc = 8'h01;
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) w[j] = rk[i-4+j];
      if (i % 16 == 0) begin
        f = w[0];
        w[0] = sub_tab[w[1]] ^ rc;
        w[1] = sub_tab[w[2]];
        w[2] = sub_tab[w[3]];
        w[3] = sub_tab[f];
        rc = dbl(rc);
      end
      for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ w[j];
    end
    for (int i = 0; i < 16; i++) s[i] = pt[127-8*i -: 8] ^ rk[i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[i+4*c] = sub_tab[s[i+4*((c+i)%4)]];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
          t[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
          t[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
          t[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*r+i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  task automatic derive_keys(input logic fn, input logic [127:0] key,
                             input logic [127:0] rnd, input logic [1:0] want);
    logic [127:0] seed;
    key_block_t b;
    if (!fn) begin
      seed = cipher(key, 128'd0);
      b = '{KIND_AK, 2'd0, cipher(key, seed ^ 128'd1), 1'b0};
      key_block_q.push_back(b);
      b = '{KIND_KDK, 2'd0, cipher(key, seed ^ 128'd2), 1'b1};
      key_block_q.push_back(b);
    end else begin
      seed = cipher(key, rnd);
      b = '{KIND_TEK, 2'd0, cipher(key, seed ^ 128'd1), want == WANT_TEK};
      key_block_q.push_back(b);
      if (want != WANT_TEK) begin
        for (int i = 0; i < KEY_BLOCKS; i++) begin
          b = '{KIND_MSK, i[1:0], cipher(key, seed ^ 128'(2 + i)),
                want == WANT_MSK && i + 1 == KEY_BLOCKS};
          key_block_q.push_back(b);
        end
        if (want != WANT_MSK)
          for (int i = 0; i < KEY_BLOCKS; i++) begin
            b = '{KIND_EMSK, i[1:0], cipher(key, seed ^ 128'(2 + KEY_BLOCKS + i)),
                  i + 1 == KEY_BLOCKS};
            key_block_q.push_back(b);
          end
      end
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    key_block_t e;
    if (rst_ni && in_valid_i && !in_stall_i)
      derive_keys(func_i, {key_hi_i, key_lo_i}, {rand_hi_i, rand_lo_i}, wanted_i);
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (key_block_q.size() == 0) begin
        $display("%0t: unexpected beat kind %0d value %h", $time, kind_i,
                 {value_hi_i, value_lo_i});
        fail_count_o++;
      end else begin
        e = key_block_q.pop_front();
        if (kind_i !== e.kind || part_i !== e.part || last_i !== e.last
            || {value_hi_i, value_lo_i} !== e.value) begin
          $display("%0t: expected kind %0d part %0d last %0b value %h", $time,
                   e.kind, e.part, e.last, e.value);
          $display("%0t:   actual kind %0d part %0d last %0b value %h", $time,
                   kind_i, part_i, last_i, {value_hi_i, value_lo_i});
          fail_count_o++;
        end
      end
    end
    pending_o = key_block_q.size();
  end
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
  import pakd_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = 1'b0;
  logic [63:0] key_hi_i = '0;
  logic [63:0] key_lo_i = '0;
  logic [63:0] rand_hi_i = '0;
  logic [63:0] rand_lo_i = '0;
  logic [1:0]  wanted_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  kind_o;
  logic [1:0]  part_o;
  logic [63:0] value_hi_o;
  logic [63:0] value_lo_o;
  logic        last_o;
  int          fail_count;
  int          pending;
  bit          stall_off = 1'b0;

  always #5 clk_i = ~clk_i;

  psk_aes_key_derivation_top u_top (.*);

  pakd_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i,
    .in_stall_i(in_stall_o),
    .func_i, .key_hi_i, .key_lo_i, .rand_hi_i, .rand_lo_i, .wanted_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .kind_i(kind_o), .part_i(part_o), .value_hi_i(value_hi_o),
    .value_lo_i(value_lo_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // random 64-bit half, biased toward all-zeros and all-ones corners
  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  // one request beat: optional random idle gap, then hold until taken
  task automatic send_req(input logic fn, input logic [63:0] kh, input logic [63:0] kl,
                          input logic [63:0] rh, input logic [63:0] rl,
                          input logic [1:0] want, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    func_i <= fn;
    key_hi_i <= kh;
    key_lo_i <= kl;
    rand_hi_i <= rh;
    rand_lo_i <= rl;
    wanted_i <= want;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // receiver back-pressure: stall length drawn per beat, off in quiet stretches
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      n = stall_off ? 0 : $urandom_range(0, 16);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      // wait for a beat to go out before drawing the next stall
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [63:0] kh, kl;
    int waitc;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: key extremes in both modes, every wanted value incl. the spare code
    send_req(1'b0, '0, '0, '0, '0, WANT_TEK, 1'b0);
    send_req(1'b0, '1, '1, '1, '1, WANT_ALT, 1'b0);
    send_req(1'b0, 64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f, rand64(), rand64(),
             WANT_MSK, 1'b0);
    send_req(1'b1, '0, '0, '0, '0, WANT_TEK, 1'b0);
    send_req(1'b1, '1, '1, '1, '1, WANT_MSK, 1'b0);
    send_req(1'b1, '0, '1, '1, '0, WANT_ALL, 1'b0);
    send_req(1'b1, '1, '0, '0, '1, WANT_ALT, 1'b0);
    send_req(1'b1, rand64(), rand64(), rand64(), rand64(), WANT_ALL, 1'b1);
    send_req(1'b1, 64'h8000_0000_0000_0000, 64'h1, 64'h1, 64'h8000_0000_0000_0000,
             WANT_MSK, 1'b1);
    send_req(1'b0, 64'h8000_0000_0000_0000, 64'h1, '0, '0, WANT_ALL, 1'b1);
    in_valid_i <= 1'b0;

    // sender holds off until the block has drained everything
    while (pending != 0) @(negedge clk_i);

    for (int i = 0; i < 220; i++) begin
      // quiet stretch with no receiver stalls and no sender gaps
      stall_off = (i >= 100 && i < 130);
      kh = pick64();
      kl = pick64();
      send_req($urandom_range(0, 3) != 0, kh, kl, pick64(), pick64(),
               2'($urandom_range(0, 3)), !stall_off);
    end
    in_valid_i <= 1'b0;
    stall_off = 1'b0;

    waitc = 0;
    while (pending != 0 && waitc < 100_000) begin
      @(negedge clk_i);
      waitc++;
    end
    repeat (200) @(negedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+sv
sv/pakd_pkg.sv
sv/pakd_aes_core.sv
sv/psk_aes_key_derivation_top.sv
bench/pakd_checker.sv
bench/tb_top.sv
